>>> hw/rtl/dmtl_pkg.sv
`default_nettype none

package dmtl_pkg;

    // geometry of the tag store
    localparam int MAX_LINES    = 1024;
    localparam int LINE_IDX_W   = $clog2(MAX_LINES);
    localparam int LINE_CNT_W   = 11;
    localparam int ADDR_W       = 32;
    localparam int TAG_W        = 32;
    localparam int BLOCK_SIZE_W = 13;

    // configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = BLOCK_SIZE_W;

    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SIZE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_COUNT = CFG_INDEX_W'(1);

    localparam logic [BLOCK_SIZE_W-1:0] BLOCK_SIZE_RESET = BLOCK_SIZE_W'(16);
    localparam logic [LINE_CNT_W-1:0]   LINE_COUNT_RESET = LINE_CNT_W'(1024);
    localparam logic [LINE_CNT_W-1:0]   LINE_COUNT_MAX   = LINE_CNT_W'(MAX_LINES);

    // serial divider
    localparam int DIV_STEPS = ADDR_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // one entry of the tag memory
    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
    } line_entry_t;

endpackage

`default_nettype wire

>>> hw/rtl/direct_mapped_tag_lookup_core.sv
`default_nettype none

// Direct-mapped cache tag lookup. Each input transaction carries one byte
// address; the block number (address / block_size_bytes) is split into a line
// index (block % line_count) and a tag (block / line_count), and one result
// transaction reports hit and line_index. A miss marks the line valid and
// stores the new tag. An address passes through one 32-step restoring division
// for the block number and a second one for index and tag, both through the
// same subtractor at one quotient bit per cycle, then the registered tag
// memory read and the compare and refill write, which waits while the
// previous result is unaccepted. in_ready is high only while no address is
// in work; a finished result waits in its output register without holding
// up the next address. After reset a clearing pass zeroes the tag memory,
// during which no address is accepted (configuration writes are taken).
module direct_mapped_tag_lookup_core (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // configuration
    input  wire logic                                 cfg_we,
    input  wire logic [dmtl_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [dmtl_pkg::CFG_DATA_W-1:0]      cfg_data,
    // address channel
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [dmtl_pkg::ADDR_W-1:0]          address,
    // result channel
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic                                      hit,
    output logic [dmtl_pkg::LINE_IDX_W-1:0]           line_index
);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_DIV1   = 6'b000100,
        ST_DIV2   = 6'b001000,
        ST_READ   = 6'b010000,
        ST_LOOKUP = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [dmtl_pkg::BLOCK_SIZE_W-1:0] block_size_reg;
    logic [dmtl_pkg::LINE_CNT_W-1:0]   line_count_reg;

    logic [dmtl_pkg::ADDR_W-1:0]       quot_reg, quot_next;
    logic [dmtl_pkg::BLOCK_SIZE_W-1:0] rem_reg, rem_next;
    logic [dmtl_pkg::BLOCK_SIZE_W-1:0] div_reg, div_next;
    logic [dmtl_pkg::STEP_W-1:0]       step_reg, step_next;
    logic [dmtl_pkg::LINE_IDX_W-1:0]   clr_reg, clr_next;

    logic                              out_valid_reg, out_valid_next;
    logic                              hit_reg, hit_next;
    logic [dmtl_pkg::LINE_IDX_W-1:0]   line_index_reg, line_index_next;

    dmtl_pkg::line_entry_t mem [dmtl_pkg::MAX_LINES];
    dmtl_pkg::line_entry_t rd_data_reg;
    dmtl_pkg::line_entry_t mem_wdata;
    logic                              mem_we;
    logic [dmtl_pkg::LINE_IDX_W-1:0]   mem_waddr;
    logic [dmtl_pkg::LINE_IDX_W-1:0]   rd_addr;

    logic [dmtl_pkg::BLOCK_SIZE_W-1:0] eff_block_size;
    logic [dmtl_pkg::LINE_CNT_W-1:0]   eff_lines;
    logic [dmtl_pkg::BLOCK_SIZE_W:0]   rem_shift;
    logic [dmtl_pkg::BLOCK_SIZE_W:0]   rem_diff;
    logic                              step_ge;
    logic [dmtl_pkg::ADDR_W-1:0]       quot_step;
    logic [dmtl_pkg::BLOCK_SIZE_W-1:0] rem_step;
    logic                              step_last;
    logic                              lookup_hit;
    logic                              out_free;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= dmtl_pkg::BLOCK_SIZE_RESET;
            line_count_reg <= dmtl_pkg::LINE_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dmtl_pkg::REG_BLOCK_SIZE:
                    block_size_reg <= cfg_data;
                dmtl_pkg::REG_LINE_COUNT:
                    line_count_reg <= cfg_data[dmtl_pkg::LINE_CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // effective geometry: zero acts as one, line count capped at the store depth
    always_comb
    begin
        eff_block_size = (block_size_reg == '0) ? dmtl_pkg::BLOCK_SIZE_W'(1) : block_size_reg;
        if (line_count_reg == '0)
            eff_lines = dmtl_pkg::LINE_CNT_W'(1);
        else if (line_count_reg > dmtl_pkg::LINE_COUNT_MAX)
            eff_lines = dmtl_pkg::LINE_COUNT_MAX;
        else
            eff_lines = line_count_reg;
    end

    // shared restoring divide step, one quotient bit per cycle
    always_comb
    begin
        rem_shift = {rem_reg, quot_reg[dmtl_pkg::ADDR_W-1]};
        rem_diff  = rem_shift - {1'b0, div_reg};
        step_ge   = (rem_shift >= {1'b0, div_reg});
        rem_step  = step_ge ? rem_diff[dmtl_pkg::BLOCK_SIZE_W-1:0]
                            : rem_shift[dmtl_pkg::BLOCK_SIZE_W-1:0];
        quot_step = {quot_reg[dmtl_pkg::ADDR_W-2:0], step_ge};
        step_last = (step_reg == dmtl_pkg::STEP_W'(dmtl_pkg::DIV_STEPS - 1));
    end

    // lookup compare against the registered memory read
    assign rd_addr    = rem_reg[dmtl_pkg::LINE_IDX_W-1:0];
    assign lookup_hit = rd_data_reg.valid && (rd_data_reg.tag == quot_reg);
    assign out_free   = !out_valid_reg || out_ready;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        quot_next       = quot_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        step_next       = step_reg;
        clr_next        = clr_reg;
        out_valid_next  = out_valid_reg;
        hit_next        = hit_reg;
        line_index_next = line_index_reg;
        mem_we          = 1'b0;
        mem_waddr       = rd_addr;
        mem_wdata       = '{valid: 1'b1, tag: quot_reg};

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + dmtl_pkg::LINE_IDX_W'(1);
                if (clr_reg == dmtl_pkg::LINE_IDX_W'(dmtl_pkg::MAX_LINES - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    quot_next  = address;
                    rem_next   = '0;
                    div_next   = eff_block_size;
                    step_next  = '0;
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                quot_next = quot_step;
                rem_next  = rem_step;
                step_next = step_reg + dmtl_pkg::STEP_W'(1);
                if (step_last)
                begin
                    // block number done, divide it by the line count next
                    rem_next   = '0;
                    div_next   = dmtl_pkg::BLOCK_SIZE_W'(eff_lines);
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                quot_next = quot_step;
                rem_next  = rem_step;
                step_next = step_reg + dmtl_pkg::STEP_W'(1);
                if (step_last)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                if (out_free)
                begin
                    mem_we          = !lookup_hit;
                    out_valid_next  = 1'b1;
                    hit_next        = lookup_hit;
                    line_index_next = rd_addr;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign line_index = line_index_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        quot_reg       <= quot_next;
        rem_reg        <= rem_next;
        div_reg        <= div_next;
        hit_reg        <= hit_next;
        line_index_reg <= line_index_next;
    end

    // tag memory, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[rd_addr];
    end

`ifndef SYNTHESIS
    // partial remainder always stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV1 || state_reg == ST_DIV2) |-> (rem_reg < div_reg))
        else $error("divider remainder not below divisor");

    // the line index reaching the memory is inside the lines in use
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> ({2'b00, rem_reg} < {4'b0000, eff_lines}))
        else $error("line index beyond line count");

    // an accepted address starts the first division
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_DIV1 && step_reg == '0))
        else $error("accepted address did not start division");

    // a result is only produced from the lookup step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_LOOKUP))
        else $error("result raised outside lookup");
`endif

endmodule

`default_nettype wire

>>> test/direct_mapped_tag_lookup_core_test.sv
`timescale 1ns / 1ps

module direct_mapped_tag_lookup_core_test;

    // one predicted lookup, kept with its address for reporting
    typedef struct packed {
        logic [dmtl_pkg::ADDR_W-1:0]     addr;
        logic                            hit;
        logic [dmtl_pkg::LINE_IDX_W-1:0] line_index;
    } lookup_t;

    // register indexes the block does not decode
    localparam logic [dmtl_pkg::CFG_INDEX_W-1:0] REG_SPARE = dmtl_pkg::CFG_INDEX_W'(2);
    localparam logic [dmtl_pkg::CFG_INDEX_W-1:0] REG_TOP   = '1;

    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 100;
    localparam int PHASE_ITEMS = 190;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [dmtl_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [dmtl_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                             in_valid  = 1'b0;
    logic                             in_ready;
    logic [dmtl_pkg::ADDR_W-1:0]      address   = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic                             hit;
    logic [dmtl_pkg::LINE_IDX_W-1:0]  line_index;

    // shadow copy of the geometry and the tag store
    logic [dmtl_pkg::BLOCK_SIZE_W-1:0] block_size_cfg;
    logic [dmtl_pkg::LINE_CNT_W-1:0]   line_count_cfg;
    bit                                line_ok [dmtl_pkg::MAX_LINES];
    logic [dmtl_pkg::TAG_W-1:0]        line_tag [dmtl_pkg::MAX_LINES];

    lookup_t                     pending_lookups [$];
    logic [dmtl_pkg::ADDR_W-1:0] recent_addrs [$];
    int                          fail_count  = 0;
    int                          idle_cycles = 0;
    int                          rx_hold     = 0;
    bit                          steady      = 1'b0;

    direct_mapped_tag_lookup_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .address    (address),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hit        (hit),
        .line_index (line_index)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [31:0] eff_block_size();
        return (block_size_cfg == '0) ? 32'd1 : 32'(block_size_cfg);
    endfunction

    function automatic logic [31:0] eff_line_count();
        if (line_count_cfg == '0)
            return 32'd1;
        if (32'(line_count_cfg) > dmtl_pkg::MAX_LINES)
            return 32'(dmtl_pkg::MAX_LINES);
        return 32'(line_count_cfg);
    endfunction

    // split the address into line and tag, then look up and refill
    function automatic lookup_t predict_lookup(input logic [dmtl_pkg::ADDR_W-1:0] a);
        logic [31:0] blk;
        logic [31:0] idx;
        logic [31:0] tag;
        lookup_t     r;
        blk          = a / eff_block_size();
        idx          = blk % eff_line_count();
        tag          = blk / eff_line_count();
        r.addr       = a;
        r.line_index = idx[dmtl_pkg::LINE_IDX_W-1:0];
        if (line_ok[idx] && line_tag[idx] == tag)
        begin
            r.hit = 1'b1;
        end
        else
        begin
            r.hit         = 1'b0;
            line_ok[idx]  = 1'b1;
            line_tag[idx] = tag;
        end
        return r;
    endfunction

    // mostly reuse of recent addresses: same block, nearby block, aliasing line
    function automatic logic [dmtl_pkg::ADDR_W-1:0] pick_address();
        logic [dmtl_pkg::ADDR_W-1:0] a;
        logic [dmtl_pkg::ADDR_W-1:0] base;
        int unsigned                 r;
        r = $urandom_range(99);
        if (recent_addrs.size() == 0 || r < 20)
        begin
            a = $urandom();
        end
        else
        begin
            base = recent_addrs[$urandom_range(recent_addrs.size() - 1)];
            if (r < 45)
                a = base;
            else if (r < 80)
                a = base + $urandom_range(2 * eff_block_size());
            else
                a = base + eff_block_size() * eff_line_count() * $urandom_range(3, 1);
        end
        recent_addrs.push_back(a);
        if (recent_addrs.size() > 24)
            void'(recent_addrs.pop_front());
        return a;
    endfunction

    // address transaction; valid is left high for the caller
    task automatic send_address(input logic [dmtl_pkg::ADDR_W-1:0] a);
        in_valid <= 1'b1;
        address  <= a;
        do
            @(posedge clk);
        while (!in_ready);
        pending_lookups.push_back(predict_lookup(a));
    endtask

    task automatic pause_sender(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // hold off until every predicted result has been taken
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_lookups.size() != 0);
    endtask

    task automatic write_reg(input logic [dmtl_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [dmtl_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == dmtl_pkg::REG_BLOCK_SIZE)
            block_size_cfg = data;
        else if (idx == dmtl_pkg::REG_LINE_COUNT)
            line_count_cfg = data[dmtl_pkg::LINE_CNT_W-1:0];
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // reset geometry: hits within a block, address extremes, aliasing on line 0
    task automatic test_default_geometry();
        send_address(32'h0000_0000);
        send_address(32'h0000_0000);
        send_address(32'h0000_000F);
        send_address(32'h0000_0010);
        send_address(32'hFFFF_FFFF);
        send_address(32'hFFFF_FFF0);
        send_address(32'h0000_4000);
        send_address(32'h0000_0000);
        wait_idle();
    endtask

    // zero, oversized and wide register values, undecoded indexes
    task automatic test_register_corners();
        write_reg(dmtl_pkg::REG_BLOCK_SIZE, '0);
        write_reg(dmtl_pkg::REG_LINE_COUNT, '0);
        send_address(32'h0000_0007);
        send_address(32'h0000_0007);
        send_address(32'h0000_0008);
        wait_idle();
        write_reg(dmtl_pkg::REG_BLOCK_SIZE, 13'd8191);
        write_reg(dmtl_pkg::REG_LINE_COUNT, 13'd2047);
        send_address(32'hFFFF_FFFF);
        send_address(32'h0000_0000);
        wait_idle();
        write_reg(dmtl_pkg::REG_LINE_COUNT, 13'h1FFF);
        send_address(32'hFFFF_FFFF);
        wait_idle();
        write_reg(dmtl_pkg::REG_LINE_COUNT, 13'h1803);
        write_reg(dmtl_pkg::REG_BLOCK_SIZE, 13'd4096);
        send_address(32'h0000_3000);
        send_address(32'h0000_5000);
        wait_idle();
        // these must leave the geometry alone
        write_reg(REG_SPARE, '1);
        write_reg(REG_TOP, 13'd1);
        send_address(32'h0000_3000);
        wait_idle();
        write_reg(dmtl_pkg::REG_BLOCK_SIZE, 13'd1);
        write_reg(dmtl_pkg::REG_LINE_COUNT, 13'd1024);
        send_address(32'h0000_03FF);
        send_address(32'hFFFF_FFFF);
        wait_idle();
        write_reg(dmtl_pkg::REG_LINE_COUNT, 13'd1);
        send_address(32'hFFFF_FFFF);
        send_address(32'hFFFF_FFFE);
        wait_idle();
    endtask

    // sender waits for each result before the next address
    task automatic test_drain_between_items();
        write_reg(dmtl_pkg::REG_BLOCK_SIZE, 13'd32);
        write_reg(dmtl_pkg::REG_LINE_COUNT, 13'd64);
        repeat (20)
        begin
            send_address(pick_address());
            wait_idle();
        end
    endtask

    task automatic run_phase(input logic [dmtl_pkg::CFG_DATA_W-1:0] bsize,
                             input logic [dmtl_pkg::CFG_DATA_W-1:0] lines,
                             input bit quiet);
        wait_idle();
        write_reg(dmtl_pkg::REG_BLOCK_SIZE, bsize);
        write_reg(dmtl_pkg::REG_LINE_COUNT, lines);
        steady <= quiet;
        repeat (PHASE_ITEMS)
        begin
            if (!quiet && $urandom_range(99) < 8)
                pause_sender($urandom_range(100, 1));
            send_address(pick_address());
        end
        wait_idle();
        steady <= 1'b0;
    endtask

    // random traffic across several geometries, extremes included
    task automatic test_random_traffic();
        run_phase(13'd16, 13'd1024, 1'b1);
        run_phase(13'd1, 13'd1, 1'b0);
        run_phase(13'd4096, 13'd1024, 1'b0);
        run_phase(13'd8191, 13'd1, 1'b0);
        run_phase(13'd0, 13'd0, 1'b0);
        run_phase(13'd64, 13'd2047, 1'b0);
        run_phase(13'd3, 13'd7, 1'b0);
        run_phase(dmtl_pkg::CFG_DATA_W'($urandom_range(4096, 1)),
                  dmtl_pkg::CFG_DATA_W'($urandom_range(1024, 1)), 1'b0);
        run_phase(dmtl_pkg::CFG_DATA_W'($urandom_range(8191)),
                  dmtl_pkg::CFG_DATA_W'($urandom_range(8191)), 1'b0);
        run_phase(dmtl_pkg::CFG_DATA_W'($urandom_range(300, 1)),
                  dmtl_pkg::CFG_DATA_W'($urandom_range(40, 1)), 1'b0);
    endtask

    // result side back-pressure: short stalls, now and then a long one
    always @(posedge clk)
    begin
        if (steady)
        begin
            out_ready <= 1'b1;
            rx_hold   <= 0;
        end
        else if (rx_hold != 0)
        begin
            out_ready <= 1'b0;
            rx_hold   <= rx_hold - 1;
        end
        else if ($urandom_range(999) < 6)
        begin
            out_ready <= 1'b0;
            rx_hold   <= ($urandom_range(7) == 0) ? $urandom_range(140, 40)
                                                  : $urandom_range(6, 1);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin : check_results
        lookup_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_lookups.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: hit=%0d line=%0d", hit, line_index);
            end
            else
            begin
                want = pending_lookups.pop_front();
                if (hit !== want.hit || line_index !== want.line_index)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"mismatch at address %h: expected hit=%0d line=%0d, ",
                                  "got hit=%0d line=%0d"},
                                 want.addr, want.hit, want.line_index, hit, line_index);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("direct_mapped_tag_lookup_core_test: done, errors");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        block_size_cfg = dmtl_pkg::BLOCK_SIZE_RESET;
        line_count_cfg = dmtl_pkg::LINE_COUNT_RESET;
        foreach (line_ok[i])
        begin
            line_ok[i]  = 1'b0;
            line_tag[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_default_geometry();
        test_register_corners();
        test_drain_between_items();
        test_random_traffic();
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("direct_mapped_tag_lookup_core_test: done, clean");
        else
            $display("direct_mapped_tag_lookup_core_test: done, errors");
        $finish;
    end

endmodule
